>>> src/slpg_pkg.sv
// Shared types, constants and color helpers of the status LED pattern generator.
// No dependencies; slpg_color, the top level and the bench refer to it by scoped names.
package slpg_pkg;

	// Channel and hue wheel constants
	localparam int unsigned CH_W       = 8;
	localparam int unsigned HUE_W      = 9;
	localparam int unsigned HUE_WRAP   = 360;
	localparam int unsigned HUE_SECTOR = 120;
	localparam logic [CH_W-1:0] CH_MAX = 8'd255;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HUE_STEP     = 3'd0,
		REG_READY_HALF   = 3'd1,
		REG_STREAM_HALF  = 3'd2,
		REG_ERROR_HALF   = 3'd3,
		REG_ACK_LENGTH   = 3'd4
	} cfg_reg_t;

	// Register reset values
	localparam logic [HUE_W-1:0] RST_HUE_STEP    = 9'd9;
	localparam logic [7:0]       RST_READY_HALF  = 8'd10;
	localparam logic [7:0]       RST_STREAM_HALF = 8'd5;
	localparam logic [7:0]       RST_ERROR_HALF  = 8'd2;
	localparam logic [7:0]       RST_ACK_LENGTH  = 8'd1;

	// Pattern codes
	typedef enum logic [2:0] {
		PAT_BOOT   = 3'd0,
		PAT_READY  = 3'd1,
		PAT_STREAM = 3'd2,
		PAT_ERROR  = 3'd3
	} pattern_t;

	// What the color stage needs to know about one tick
	typedef struct packed {
		logic [2:0]       pattern;
		logic             white;
		logic [HUE_W-1:0] hue_phase;
		logic             ready_on;
		logic             stream_on;
		logic             error_on;
	} view_t;

	// Linear ramp over one sector: x*255/120 == x*17/8 for x in 0..120
	function automatic logic [CH_W-1:0] ramp(input logic [6:0] x);
		logic [10:0] p;
		p = {4'd0, x} * 11'd17;
		return p[10:3];
	endfunction

endpackage

>>> src/slpg_if.sv
// Valid/ready channel interfaces of the status LED pattern generator.
// Depends on nothing; field widths match slpg_pkg.

// One display tick: pattern code and acknowledge request
interface slpg_tick_if;
	logic       valid;
	logic       ready;
	logic [2:0] pattern;
	logic       ack_request;

	modport source (output valid, output pattern, output ack_request, input ready);
	modport sink   (input valid, input pattern, input ack_request, output ready);
endinterface

// One RGB color result
interface slpg_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> src/slpg_blink.sv
// One blink generator: half-period counter and on/off level.
// Uses no package items; instantiated by the top level once per blinking pattern.
module slpg_blink #(
	parameter int unsigned HP_W = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] half_ticks,
	output logic       level
);

	logic [HP_W-1:0] count_q;
	logic            level_q;
	logic [HP_W-1:0] lim;
	logic [HP_W-1:0] count_inc;
	logic            wrap;

	// Limit is the half-period cut to the counter width; zero counts as one
	always_comb begin
		lim = HP_W'(half_ticks);
		if (lim == '0) begin
			lim = HP_W'(1);
		end
		count_inc = count_q + HP_W'(1);
		wrap      = (count_inc >= lim) || (count_inc == '0);
	end

	// Advance the count; toggle the level at the end of each half-period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			level_q <= 1'b1;
		end else if (advance) begin
			if (wrap) begin
				count_q <= '0;
				level_q <= ~level_q;
			end else begin
				count_q <= count_inc;
			end
		end
	end

	assign level = level_q;

endmodule

>>> src/slpg_color.sv
// Color selection for one tick: white flash, hue wheel, blinks or black.
// Depends on slpg_pkg for the view struct, pattern codes and the ramp function.
module slpg_color (
	input  slpg_pkg::view_t view,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue
);

	logic [8:0] h;
	logic [8:0] ofs;
	logic [6:0] s;
	logic [7:0] rise;
	logic [7:0] fall;
	logic [1:0] sector;

	// Split the hue into sector and offset within it
	always_comb begin
		h = view.hue_phase;
		if (h < 9'(slpg_pkg::HUE_SECTOR)) begin
			sector = 2'd0;
			ofs    = h;
		end else if (h < 9'(2 * slpg_pkg::HUE_SECTOR)) begin
			sector = 2'd1;
			ofs    = h - 9'(slpg_pkg::HUE_SECTOR);
		end else begin
			sector = 2'd2;
			ofs    = h - 9'(2 * slpg_pkg::HUE_SECTOR);
		end
		s    = ofs[6:0];
		rise = slpg_pkg::ramp(s);
		fall = slpg_pkg::ramp(7'(slpg_pkg::HUE_SECTOR) - s);
	end

	// Pick the color; the flash overrides every pattern
	always_comb begin
		red   = '0;
		green = '0;
		blue  = '0;
		if (view.white) begin
			red   = slpg_pkg::CH_MAX;
			green = slpg_pkg::CH_MAX;
			blue  = slpg_pkg::CH_MAX;
		end else begin
			unique case (view.pattern)
				slpg_pkg::PAT_BOOT: begin
					unique case (sector)
						2'd0: begin
							red   = fall;
							green = rise;
						end
						2'd1: begin
							green = fall;
							blue  = rise;
						end
						default: begin
							red  = rise;
							blue = fall;
						end
					endcase
				end
				slpg_pkg::PAT_READY: begin
					if (view.ready_on) begin
						green = slpg_pkg::CH_MAX;
					end
				end
				slpg_pkg::PAT_STREAM: begin
					if (view.stream_on) begin
						green = slpg_pkg::CH_MAX;
						blue  = slpg_pkg::CH_MAX;
					end
				end
				slpg_pkg::PAT_ERROR: begin
					if (view.error_on) begin
						red = slpg_pkg::CH_MAX;
					end
				end
				default: begin
					red = '0;
				end
			endcase
		end
	end

endmodule

>>> src/status_led_pattern_generator.sv
// Status LED pattern generator: takes one display tick per cycle while colors are taken and
// returns one RGB color per tick. A taken tick is held in the input register; its color is
// loaded into the color register when the color stage fires and is offered from then on.
// The tick channel stays ready whenever the input register is empty or its tick moves on in
// the same cycle; it stalls only when a color waits untaken and a second tick is already held.
// One tick per cycle is sustained as long as colors are taken. The single color stage also
// advances the hue phase, the three blink counters and the acknowledge flash once per tick.
// Depends on slpg_pkg, slpg_if, slpg_blink and slpg_color.
module status_led_pattern_generator #(
	parameter int unsigned HALF_PERIOD_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	slpg_tick_if.sink                           tick,
	slpg_rgb_if.source                          led,
	input  logic                                cfg_write,
	input  logic [slpg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [slpg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Configuration registers
	logic [8:0] hue_step_q;
	logic [7:0] ready_half_q;
	logic [7:0] stream_half_q;
	logic [7:0] error_half_q;
	logic [7:0] ack_length_q;
	logic [8:0] step_mod;

	// Pipeline and state
	logic       v_s1;
	logic [2:0] pattern_s1;
	logic       ack_s1;
	logic       v_s2;
	logic [7:0] red_s2;
	logic [7:0] green_s2;
	logic [7:0] blue_s2;
	logic [8:0] hue_phase_q;
	logic       ack_active_q;
	logic [7:0] ack_count_q;

	logic       fire;
	logic       ack_on;
	logic [7:0] ack_cnt;
	logic [7:0] ack_inc;
	logic [7:0] ack_lim;
	logic       ack_done;
	logic [9:0] hue_sum;
	logic [8:0] hue_next;
	logic       ready_on;
	logic       stream_on;
	logic       error_on;
	logic [7:0] red_c;
	logic [7:0] green_c;
	logic [7:0] blue_c;
	slpg_pkg::view_t view;

	// Store the hue step already reduced below 360
	assign step_mod = (cfg_data >= 9'(slpg_pkg::HUE_WRAP)) ?
		cfg_data - 9'(slpg_pkg::HUE_WRAP) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_step_q    <= slpg_pkg::RST_HUE_STEP;
			ready_half_q  <= slpg_pkg::RST_READY_HALF;
			stream_half_q <= slpg_pkg::RST_STREAM_HALF;
			error_half_q  <= slpg_pkg::RST_ERROR_HALF;
			ack_length_q  <= slpg_pkg::RST_ACK_LENGTH;
		end else if (cfg_write) begin
			unique case (slpg_pkg::cfg_reg_t'(cfg_index))
				slpg_pkg::REG_HUE_STEP:    hue_step_q    <= step_mod;
				slpg_pkg::REG_READY_HALF:  ready_half_q  <= cfg_data[7:0];
				slpg_pkg::REG_STREAM_HALF: stream_half_q <= cfg_data[7:0];
				slpg_pkg::REG_ERROR_HALF:  error_half_q  <= cfg_data[7:0];
				slpg_pkg::REG_ACK_LENGTH:  ack_length_q  <= cfg_data[7:0];
				default: begin
					hue_step_q <= hue_step_q;
				end
			endcase
		end
	end

	// Handshake: the color stage fires when its result register is free or being drained
	assign fire       = v_s1 && (!v_s2 || led.ready);
	assign tick.ready = !v_s1 || fire;

	// Hold the accepted tick in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (tick.ready) begin
			v_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			pattern_s1 <= tick.pattern;
			ack_s1     <= tick.ack_request;
		end
	end

	// Acknowledge flash: a request restarts it, then it counts shown ticks
	always_comb begin
		ack_on  = ack_s1 || ack_active_q;
		ack_cnt = ack_s1 ? 8'd0 : ack_count_q;
		ack_inc = ack_cnt + 8'd1;
		ack_lim = (ack_length_q == 8'd0) ? 8'd1 : ack_length_q;
		ack_done = (ack_inc >= ack_lim) || (ack_inc == 8'd0);
	end

	// Hue phase advance modulo 360
	always_comb begin
		hue_sum  = {1'b0, hue_phase_q} + {1'b0, hue_step_q};
		hue_next = (hue_sum >= 10'(slpg_pkg::HUE_WRAP)) ?
			9'(hue_sum - 10'(slpg_pkg::HUE_WRAP)) : hue_sum[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_phase_q  <= '0;
			ack_active_q <= 1'b0;
			ack_count_q  <= '0;
		end else if (fire) begin
			hue_phase_q <= hue_next;
			if (ack_on) begin
				ack_active_q <= !ack_done;
				ack_count_q  <= ack_done ? 8'd0 : ack_inc;
			end
		end
	end

	// Blink generators advance on every tick
	slpg_blink #(.HP_W(HALF_PERIOD_BITS)) u_ready_blink (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (fire),
		.half_ticks (ready_half_q),
		.level      (ready_on)
	);

	slpg_blink #(.HP_W(HALF_PERIOD_BITS)) u_stream_blink (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (fire),
		.half_ticks (stream_half_q),
		.level      (stream_on)
	);

	slpg_blink #(.HP_W(HALF_PERIOD_BITS)) u_error_blink (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (fire),
		.half_ticks (error_half_q),
		.level      (error_on)
	);

	// Render the color from the state as it stands before the advance
	always_comb begin
		view.pattern   = pattern_s1;
		view.white     = ack_on;
		view.hue_phase = hue_phase_q;
		view.ready_on  = ready_on;
		view.stream_on = stream_on;
		view.error_on  = error_on;
	end

	slpg_color u_color (
		.view  (view),
		.red   (red_c),
		.green (green_c),
		.blue  (blue_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (fire) begin
			v_s2 <= 1'b1;
		end else if (led.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			red_s2   <= red_c;
			green_s2 <= green_c;
			blue_s2  <= blue_c;
		end
	end

	assign led.valid = v_s2;
	assign led.red   = red_s2;
	assign led.green = green_s2;
	assign led.blue  = blue_s2;

endmodule

>>> test/tb_top.sv
// Self-checking bench for the status LED pattern generator: drives display ticks, predicts
// each RGB color and compares it with the block's output, across several register settings.
// Depends on slpg_pkg, slpg_if and status_led_pattern_generator.
module tb_top;

	localparam logic [2:0] PAT_OFF_FIRST = 3'd4;
	localparam logic [2:0] PAT_OFF_LAST  = 3'd7;
	localparam int unsigned LONG_HOLD    = 300;

	typedef struct packed {
		logic [slpg_pkg::CH_W-1:0] red;
		logic [slpg_pkg::CH_W-1:0] green;
		logic [slpg_pkg::CH_W-1:0] blue;
	} led_color_t;

	typedef struct packed {
		logic [2:0] pattern;
		logic       ack;
	} tick_item_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [slpg_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [slpg_pkg::CFG_DATA_W-1:0] cfg_data;

	slpg_tick_if tick_bus ();
	slpg_rgb_if  led_bus ();

	status_led_pattern_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_bus.sink),
		.led       (led_bus.source),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register copies held by the predictor
	logic [slpg_pkg::HUE_W-1:0] hue_step;
	logic [7:0]                 ready_half;
	logic [7:0]                 stream_half;
	logic [7:0]                 error_half;
	logic [7:0]                 ack_len;

	// Predicted display state
	logic [slpg_pkg::HUE_W-1:0] hue_now;
	logic [7:0]       ready_cnt, stream_cnt, error_cnt, ack_cnt;
	logic             ready_lvl, stream_lvl, error_lvl, ack_on;

	tick_item_t pending_ticks[$];
	led_color_t colors_due[$];

	int  ticks_issued;
	int  ticks_taken;
	int  colors_checked;
	int  fail_count;
	int  settings_done;
	int  tick_gap;
	int  led_stall;
	int  led_hold_left;
	bit  steady_flow;
	logic tick_taken;
	logic led_taken;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [slpg_pkg::CH_W-1:0] ramp_level(input int unsigned x);
		int unsigned v;
		v = (x * slpg_pkg::CH_MAX) / slpg_pkg::HUE_SECTOR;
		return v[slpg_pkg::CH_W-1:0];
	endfunction

	// Advance one blink: count up, wrap at the half-period and toggle the level
	function automatic void blink_step(inout logic [7:0] cnt, inout logic lvl,
			input logic [7:0] half);
		int unsigned lim;
		lim = (half == 8'd0) ? 1 : half;
		cnt = cnt + 8'd1;
		if (cnt >= lim || cnt == 8'd0) begin
			cnt = 8'd0;
			lvl = ~lvl;
		end
	endfunction

	// Work out the color of one tick and advance the display state
	function automatic led_color_t render_tick(input logic [2:0] pat, input logic ack_req);
		led_color_t c;
		int unsigned lim;
		int unsigned h;
		int unsigned s;
		c = '0;
		h = hue_now;
		if (ack_req) begin
			ack_on = 1'b1;
			ack_cnt = 8'd0;
		end
		if (ack_on) begin
			c = {slpg_pkg::CH_MAX, slpg_pkg::CH_MAX, slpg_pkg::CH_MAX};
			lim = (ack_len == 8'd0) ? 1 : ack_len;
			ack_cnt = ack_cnt + 8'd1;
			if (ack_cnt >= lim || ack_cnt == 8'd0) begin
				ack_on = 1'b0;
				ack_cnt = 8'd0;
			end
		end else begin
			case (pat)
				slpg_pkg::PAT_BOOT: begin
					h = h % slpg_pkg::HUE_WRAP;
					if (h < slpg_pkg::HUE_SECTOR) begin
						c.red   = ramp_level(slpg_pkg::HUE_SECTOR - h);
						c.green = ramp_level(h);
					end else if (h < 2 * slpg_pkg::HUE_SECTOR) begin
						s = h - slpg_pkg::HUE_SECTOR;
						c.green = ramp_level(slpg_pkg::HUE_SECTOR - s);
						c.blue  = ramp_level(s);
					end else begin
						s = h - 2 * slpg_pkg::HUE_SECTOR;
						c.red  = ramp_level(s);
						c.blue = ramp_level(slpg_pkg::HUE_SECTOR - s);
					end
				end
				slpg_pkg::PAT_READY: if (ready_lvl) c.green = slpg_pkg::CH_MAX;
				slpg_pkg::PAT_STREAM: if (stream_lvl) begin
					c.green = slpg_pkg::CH_MAX;
					c.blue  = slpg_pkg::CH_MAX;
				end
				slpg_pkg::PAT_ERROR: if (error_lvl) c.red = slpg_pkg::CH_MAX;
				default: ;
			endcase
		end
		// Hue and blinks run on every tick, flash or not
		h = hue_now;
		h = (h % slpg_pkg::HUE_WRAP + hue_step) % slpg_pkg::HUE_WRAP;
		hue_now = h[slpg_pkg::HUE_W-1:0];
		blink_step(ready_cnt, ready_lvl, ready_half);
		blink_step(stream_cnt, stream_lvl, stream_half);
		blink_step(error_cnt, error_lvl, error_half);
		return c;
	endfunction

	function automatic void check_channel(input string name, input logic [7:0] want,
			input logic [7:0] seen);
		if (seen !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, seen);
			fail_count++;
		end
	endfunction

	// Sample both channels; check colors, predict on each tick transfer
	always @(posedge clk) begin : watch_channels
		led_color_t seen;
		led_color_t want;
		tick_taken <= tick_bus.valid && tick_bus.ready;
		led_taken  <= led_bus.valid && led_bus.ready;
		if (arst_n && led_bus.valid && led_bus.ready) begin
			seen = {led_bus.red, led_bus.green, led_bus.blue};
			if (colors_due.size() == 0) begin
				$error("color %0d/%0d/%0d arrived with no tick waiting",
					seen.red, seen.green, seen.blue);
				fail_count++;
			end else begin
				want = colors_due.pop_front();
				check_channel("red", want.red, seen.red);
				check_channel("green", want.green, seen.green);
				check_channel("blue", want.blue, seen.blue);
				colors_checked++;
			end
		end
		if (arst_n && tick_bus.valid && tick_bus.ready) begin
			colors_due.push_back(render_tick(tick_bus.pattern, tick_bus.ack_request));
			ticks_taken++;
		end
	end

	// Offer ticks from the pending queue; hold each one until its transfer
	always @(negedge clk) begin : drive_ticks
		tick_item_t item;
		if (!(tick_bus.valid && !tick_taken)) begin
			if (tick_gap > 0) begin
				tick_bus.valid <= 1'b0;
				tick_gap--;
			end else if (pending_ticks.size() != 0) begin
				item = pending_ticks.pop_front();
				tick_bus.valid       <= 1'b1;
				tick_bus.pattern     <= item.pattern;
				tick_bus.ack_request <= item.ack;
				tick_gap = steady_flow ? 0 : $urandom_range(0, 7);
			end else begin
				tick_bus.valid <= 1'b0;
			end
		end
	end

	// Stall the color channel after each transfer, or count down the long hold-off
	always @(negedge clk) begin : drive_led_ready
		if (led_taken)
			led_stall = steady_flow ? 0 : $urandom_range(0, 7);
		if (led_hold_left > 0) begin
			led_bus.ready <= 1'b0;
			led_hold_left--;
		end else if (led_stall > 0) begin
			led_bus.ready <= 1'b0;
			led_stall--;
		end else begin
			led_bus.ready <= 1'b1;
		end
	end

	task automatic queue_tick(input logic [2:0] pat, input logic ack);
		pending_ticks.push_back('{pattern: pat, ack: ack});
		ticks_issued++;
	endtask

	// Queue runs of one pattern with occasional acknowledge requests
	task automatic queue_random(input int count, input int ack_odds);
		logic [2:0] pat;
		int run;
		run = 0;
		pat = slpg_pkg::PAT_BOOT;
		for (int i = 0; i < count; i++) begin
			if (run == 0) begin
				pat = 3'($urandom_range(0, 7));
				run = $urandom_range(1, 24);
			end
			run--;
			queue_tick(pat, $urandom_range(0, ack_odds - 1) == 0);
		end
	endtask

	task automatic write_reg(input slpg_pkg::cfg_reg_t idx,
			input logic [slpg_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
	endtask

	// Write all five registers while idle and mirror them in the predictor
	task automatic program_regs(input logic [slpg_pkg::CFG_DATA_W-1:0] hue, rdy, strm, err,
			ack);
		write_reg(slpg_pkg::REG_HUE_STEP, hue);
		write_reg(slpg_pkg::REG_READY_HALF, rdy);
		write_reg(slpg_pkg::REG_STREAM_HALF, strm);
		write_reg(slpg_pkg::REG_ERROR_HALF, err);
		write_reg(slpg_pkg::REG_ACK_LENGTH, ack);
		@(negedge clk);
		cfg_write = 1'b0;
		hue_step    = hue;
		ready_half  = rdy[7:0];
		stream_half = strm[7:0];
		error_half  = err[7:0];
		ack_len     = ack[7:0];
		settings_done++;
	endtask

	// Wait until every queued tick has come back as a color, then let the pipe drain
	task automatic finish_phase();
		while (colors_checked < ticks_issued)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = slpg_pkg::REG_HUE_STEP;
		cfg_data  = '0;
		tick_bus.valid = 1'b0;
		tick_bus.pattern = slpg_pkg::PAT_BOOT;
		tick_bus.ack_request = 1'b0;
		led_bus.ready = 1'b0;
		tick_taken = 1'b0;
		led_taken = 1'b0;
		ticks_issued = 0;
		ticks_taken = 0;
		colors_checked = 0;
		fail_count = 0;
		settings_done = 0;
		tick_gap = 0;
		led_stall = 0;
		led_hold_left = 0;
		steady_flow = 1'b0;
		hue_step    = slpg_pkg::RST_HUE_STEP;
		ready_half  = slpg_pkg::RST_READY_HALF;
		stream_half = slpg_pkg::RST_STREAM_HALF;
		error_half  = slpg_pkg::RST_ERROR_HALF;
		ack_len     = slpg_pkg::RST_ACK_LENGTH;
		hue_now = '0;
		ready_cnt = 8'd0;
		stream_cnt = 8'd0;
		error_cnt = 8'd0;
		ack_cnt = 8'd0;
		ready_lvl = 1'b1;
		stream_lvl = 1'b1;
		error_lvl = 1'b1;
		ack_on = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every pattern code, flash on several patterns, back-to-back restart
		queue_tick(slpg_pkg::PAT_BOOT, 1'b0);
		queue_tick(slpg_pkg::PAT_BOOT, 1'b0);
		queue_tick(slpg_pkg::PAT_READY, 1'b0);
		queue_tick(slpg_pkg::PAT_STREAM, 1'b0);
		queue_tick(slpg_pkg::PAT_ERROR, 1'b0);
		for (int c = PAT_OFF_FIRST; c <= PAT_OFF_LAST; c++)
			queue_tick(3'(c), 1'b0);
		queue_tick(slpg_pkg::PAT_BOOT, 1'b1);
		queue_tick(slpg_pkg::PAT_BOOT, 1'b0);
		queue_tick(slpg_pkg::PAT_ERROR, 1'b1);
		queue_tick(slpg_pkg::PAT_STREAM, 1'b1);
		queue_tick(slpg_pkg::PAT_STREAM, 1'b1);
		queue_tick(slpg_pkg::PAT_STREAM, 1'b0);
		queue_tick(PAT_OFF_LAST, 1'b1);
		queue_tick(slpg_pkg::PAT_READY, 1'b0);
		queue_tick(slpg_pkg::PAT_READY, 1'b0);
		queue_tick(slpg_pkg::PAT_ERROR, 1'b0);
		queue_random(100, 6);
		finish_phase();

		// Largest values: long blinks and a long flash
		program_regs(9'd359, 9'd255, 9'd255, 9'd255, 9'd255);
		queue_random(160, 150);
		finish_phase();

		// Zero half-periods and zero flash length act as one tick; hue stands still
		steady_flow = 1'b1;
		program_regs(9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
		queue_random(140, 5);
		finish_phase();

		// Hue step beyond a full turn, shortest blinks
		steady_flow = 1'b0;
		program_regs(9'd511, 9'd1, 9'd1, 9'd1, 9'd1);
		queue_random(140, 5);
		finish_phase();

		// Upper data bit set on the narrow registers; hold the color side off so
		// the block fills and stalls its tick input
		steady_flow = 1'b1;
		program_regs(9'd400, 9'h1FF, 9'h100, 9'h1C3, 9'h101);
		queue_random(160, 7);
		@(posedge clk);
		led_hold_left = LONG_HOLD;
		finish_phase();

		// Random settings, with and without idling
		for (int p = 0; p < 3; p++) begin
			steady_flow = (p == 1);
			program_regs(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
				9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
				9'($urandom_range(0, 511)));
			queue_random(130, 12);
			finish_phase();
		end

		if (colors_due.size() != 0) begin
			$error("%0d predicted colors never arrived", colors_due.size());
			fail_count++;
		end
		$display("summary: %0d ticks taken over %0d register settings, %0d colors checked",
			ticks_taken, settings_done + 1, colors_checked);
		$display("summary: %0d mismatches or stray colors", fail_count);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#4000000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
